@@ design/ktr_pkg.sv @@
// shared types and constants for the keyed target registry
// no dependencies

package ktr_pkg;

   typedef enum logic [2:0] {
      CMD_REMEMBER   = 3'd0,
      CMD_ERASE      = 3'd1,
      CMD_INVALIDATE = 3'd2,
      CMD_RETAIN     = 3'd3,
      CMD_SNAPSHOT   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_RESULT
   } state_type;

   // one stored record
   typedef struct packed {
      logic [31:0] node_id;
      logic [31:0] obj_id;
      logic [31:0] rsrc_id;
      logic [63:0] uuid_high;
      logic [63:0] uuid_low;
      logic [63:0] generation;
   } record_type;

endpackage

@@ design/keyed_target_registry_unit.sv @@
// keyed target registry top level: command sequencer around one record memory
// depends on ktr_pkg

// Commands are taken when start is high and busy is low. Each command walks the
// stored records through a single record memory with registered read data,
// one record per cycle: erase, invalidate and retain step through scan and
// result, and remember through scan, a possible append write and result; a
// rejected remember or an unknown command holds busy for one cycle. Each of
// these gives one result. Snapshot gives one result per record on consecutive
// cycles (one result when empty), then frees. Results appear on rsp_ ports for
// one cycle under rsp_valid and cannot be stalled. Removals compact in place
// during the same scan: the read pointer runs ahead of the write pointer, so no
// entry is overwritten before it is read. The memory needs no clearing after
// reset.
module keyed_target_registry_unit
   import ktr_pkg::*;
#(
   parameter int MAX_ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_node_id,
   input  logic [31:0] req_object_id,
   input  logic [31:0] req_resource_id,
   input  logic [63:0] req_uuid_high,
   input  logic [63:0] req_uuid_low,
   input  logic [63:0] req_generation,
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [5:0]  rsp_count,
   output logic        rsp_entry_valid,
   output logic [31:0] rsp_out_node_id,
   output logic [31:0] rsp_out_object_id,
   output logic [31:0] rsp_out_resource_id,
   output logic [63:0] rsp_out_uuid_high,
   output logic [63:0] rsp_out_uuid_low,
   output logic [63:0] rsp_out_generation,
   output logic        rsp_last
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   record_type mem [MAX_ENTRIES];
   record_type rdata_ff;

   state_type state_ff, state_in;
   logic [5:0]    cap_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ff, rd_in;     // next address to issue
   logic [CW-1:0] wr_ff, wr_in;     // compaction write pointer
   logic          pend_ff, pend_in; // read data valid this cycle
   logic [CW-1:0] pidx_ff, pidx_in; // index of pending read
   logic          found_ff, found_in;
   logic [CW-1:0] fidx_ff, fidx_in;
   logic          ok_ff, ok_in;
   logic [2:0]    cmd_ff;
   record_type    req_ff;

   logic          we;
   logic [AW-1:0] waddr;
   record_type    wdata;
   logic          re;
   logic [AW-1:0] raddr;

   logic          drop, key_hit, node_hit, stale;
   logic [CW-1:0] cap_eff;

   // response registers
   logic        v_ff, v_in, rok_ff, rok_in, ev_ff, ev_in, last_ff, last_in;
   logic [5:0]  rcnt_ff, rcnt_in;
   record_type  rrec_ff, rrec_in;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   assign node_hit = rdata_ff.node_id == req_ff.node_id;
   assign key_hit  = node_hit && (rdata_ff.obj_id == req_ff.obj_id);
   assign stale    = (rdata_ff.uuid_high != req_ff.uuid_high) ||
                     (rdata_ff.uuid_low != req_ff.uuid_low) ||
                     (rdata_ff.generation != req_ff.generation);
   assign cap_eff  = ({2'b0, cap_ff} > 8'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                        : CW'(cap_ff);

   always_comb begin
      case (cmd_ff)
         CMD_ERASE:      drop = key_hit;
         CMD_INVALIDATE: drop = node_hit;
         CMD_RETAIN:     drop = node_hit && stale;
         default:        drop = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      pend_in  = 1'b0;
      pidx_in  = rd_ff;
      found_in = found_ff;
      fidx_in  = fidx_ff;
      ok_in    = ok_ff;
      we       = 1'b0;
      waddr    = wr_ff[AW-1:0];
      wdata    = rdata_ff;
      re       = 1'b0;
      raddr    = rd_ff[AW-1:0];
      v_in     = 1'b0;
      rok_in   = ok_ff;
      rcnt_in  = 6'(count_ff);
      ev_in    = 1'b0;
      last_in  = 1'b1;
      rrec_in  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_in    = '0;
            wr_in    = '0;
            found_in = 1'b0;
            ok_in    = 1'b1;
            if (start) begin
               if (req_cmd == CMD_REMEMBER && (cap_ff == 6'd0 || req_node_id == 32'd0 ||
                   req_object_id == 32'd0 || req_resource_id == 32'd0)) begin
                  ok_in    = 1'b0;
                  state_in = ST_RESULT;
               end else if (req_cmd > CMD_SNAPSHOT) begin
                  ok_in    = 1'b0;
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue next read
            if (rd_ff < count_ff) begin
               re      = 1'b1;
               pend_in = 1'b1;
               rd_in   = rd_ff + 1'b1;
            end
            if (pend_ff) begin
               if (cmd_ff == CMD_SNAPSHOT) begin
                  v_in    = 1'b1;
                  rok_in  = 1'b1;
                  ev_in   = 1'b1;
                  rrec_in = rdata_ff;
                  last_in = (pidx_ff + 1'b1) == count_ff;
               end else if (cmd_ff == CMD_REMEMBER) begin
                  if (key_hit && !found_ff) begin
                     found_in = 1'b1;
                     fidx_in  = pidx_ff;
                  end
               end else if (!drop) begin
                  we    = wr_ff != pidx_ff;
                  wr_in = wr_ff + 1'b1;
               end
            end
            if (rd_ff >= count_ff && !pend_ff) begin
               unique case (cmd_ff)
                  CMD_SNAPSHOT: begin
                     if (count_ff == '0) begin
                        v_in   = 1'b1;
                        rok_in = 1'b1;
                     end
                     state_in = ST_IDLE;
                  end
                  CMD_REMEMBER: state_in = ST_WRITE;
                  CMD_ERASE: begin
                     ok_in    = wr_ff != count_ff;
                     count_in = wr_ff;
                     state_in = ST_RESULT;
                  end
                  default: begin
                     count_in = wr_ff;
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end
         ST_WRITE: begin
            wdata = req_ff;
            if (found_ff) begin
               we    = 1'b1;
               waddr = fidx_ff[AW-1:0];
            end else if (count_ff >= cap_eff) begin
               ok_in = 1'b0;
            end else begin
               we       = 1'b1;
               waddr    = count_ff[AW-1:0];
               count_in = count_ff + 1'b1;
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            v_in     = 1'b1;
            rok_in   = ok_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff   <= 6'd32;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         v_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) cap_ff <= csr_wdata;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         v_ff     <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff    <= rd_in;
      wr_ff    <= wr_in;
      pidx_ff  <= pidx_in;
      found_ff <= found_in;
      fidx_ff  <= fidx_in;
      ok_ff    <= ok_in;
      rok_ff   <= rok_in;
      rcnt_ff  <= rcnt_in;
      ev_ff    <= ev_in;
      last_ff  <= last_in;
      rrec_ff  <= rrec_in;
      if (state_ff == ST_IDLE && start) begin
         cmd_ff                <= req_cmd;
         req_ff.node_id        <= req_node_id;
         req_ff.obj_id         <= req_object_id;
         req_ff.rsrc_id        <= req_resource_id;
         req_ff.uuid_high      <= req_uuid_high;
         req_ff.uuid_low       <= req_uuid_low;
         req_ff.generation     <= req_generation;
      end
   end

   // busy also covers the cycle where the last response is registered
   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = v_ff;
   assign rsp_ok              = rok_ff;
   assign rsp_count           = rcnt_ff;
   assign rsp_entry_valid     = ev_ff;
   assign rsp_out_node_id     = rrec_ff.node_id;
   assign rsp_out_object_id   = rrec_ff.obj_id;
   assign rsp_out_resource_id = rrec_ff.rsrc_id;
   assign rsp_out_uuid_high   = rrec_ff.uuid_high;
   assign rsp_out_uuid_low    = rrec_ff.uuid_low;
   assign rsp_out_generation  = rrec_ff.generation;
   assign rsp_last            = last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES)) else $error("count above depth");
   a_wr_behind: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> wr_ff <= rd_ff) else $error("write passed read");
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_out_node_id == 32'd0 && rsp_last)
      else $error("bad control response");
`endif

endmodule
